[rtl/mgsa_pkg.sv]
package mgsa_pkg;

  localparam int unsigned Slots      = 64;
  localparam int unsigned IdCount    = 1024;
  localparam int unsigned SlotW      = $clog2(Slots);
  localparam int unsigned IdW        = $clog2(IdCount);
  localparam int unsigned CfgW       = 7;
  localparam int unsigned AddrW      = 1;
  localparam int unsigned ScoreW     = SlotW;
  // guest table entry: valid bit plus slot index
  localparam int unsigned EntryW     = SlotW + 1;
  localparam logic [CfgW-1:0] SlotsReset = CfgW'(Slots);

  localparam logic [AddrW-1:0] RegSlotsInUse = 1'b0;

  localparam logic KindArrive = 1'b0;
  localparam logic KindLeave  = 1'b1;

  typedef struct packed {
    logic          kind;
    logic [IdW-1:0] guest_id;
  } req_t;

  typedef struct packed {
    logic [6:0] slot;
    logic       row_full;
  } rsp_t;

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StLook  = 7'b0000100,
    StScan  = 7'b0001000,
    StWrite = 7'b0010000,
    StLeave = 7'b0100000,
    StFree  = 7'b1000000
  } state_e;

endpackage

[rtl/max_gap_slot_allocator_core.sv]
// Channel  | Direction | Payload              | Handshake
// request  | in        | req_t kind, guest_id | req_valid_i / req_ready_o
// response | out       | rsp_t slot, row_full | rsp_valid_o / rsp_ready_i
// config   | in        | slots_in_use @ 0x0   | APB, pready always high
//
// An arrival reads the occupancy memory once per slot of the row to set
// the scan; a departure reads the guest table, then writes the occupancy
// memory. After reset a clearing pass walks the guest table and the
// occupancy memory; no request is taken meanwhile. A response waits in an
// output register; the next request waits until it is claimed.
module max_gap_slot_allocator_core
  import mgsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output rsp_t             rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW+1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  state_e state_q, state_d;
  logic [CfgW-1:0] cfg_q;
  logic [SlotW:0]  len;
  logic [SlotW:0]  idx_q, idx_d;      // next slot address to read
  logic [SlotW:0]  pos_q, pos_d;      // slot whose data is arriving
  logic            inrun_q, inrun_d;
  logic [SlotW-1:0] start_q, start_d;
  logic            found_q, found_d;
  logic [ScoreW-1:0] best_q, best_d;
  logic [SlotW-1:0] place_q, place_d;
  logic [IdW-1:0]  id_q;
  logic [IdW:0]    clr_q, clr_d;
  logic            rsp_valid_q, rsp_valid_d;
  rsp_t            rsp_q, rsp_d;

  logic            occ_we, occ_wd, occ_rd;
  logic [SlotW-1:0] occ_wa, occ_ra;
  logic            gt_we;
  logic [IdW-1:0]  gt_wa, gt_ra;
  logic [EntryW-1:0] gt_wd, gt_rd;

  mgsa_ram #(.Width(1), .Depth(Slots)) u_occ (
    .clk_i, .we_i(occ_we), .waddr_i(occ_wa), .wdata_i(occ_wd),
    .raddr_i(occ_ra), .rdata_o(occ_rd)
  );

  mgsa_ram #(.Width(EntryW), .Depth(IdCount)) u_guest (
    .clk_i, .we_i(gt_we), .waddr_i(gt_wa), .wdata_i(gt_wd),
    .raddr_i(gt_ra), .rdata_o(gt_rd)
  );

  // clamp row length to 1..Slots
  always_comb begin
    if (cfg_q == '0) begin
      len = (SlotW+1)'(1);
    end else if ({1'b0, cfg_q} > 8'(Slots)) begin
      len = (SlotW+1)'(Slots);
    end else begin
      len = (SlotW+1)'(cfg_q);
    end
  end

  assign pready      = 1'b1;
  assign prdata      = 32'(cfg_q);
  assign req_ready_o = (state_q == StIdle) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // run scoring for the run ending at the slot before pos_q
  logic [SlotW-1:0] run_e, run_score, run_where;
  logic             run_end, run_better;
  always_comb begin
    run_e = SlotW'(pos_q - 1'b1);
    if (start_q == '0) begin
      run_score = run_e;
      run_where = '0;
    end else if ({1'b0, run_e} == len - 1'b1) begin
      run_score = run_e - start_q;
      run_where = run_e;
    end else begin
      run_score = (run_e - start_q) >> 1;
      run_where = SlotW'(({1'b0, start_q} + {1'b0, run_e}) >> 1);
    end
    run_end    = inrun_q && ((pos_q == len) || occ_rd);
    run_better = !found_q || (run_score > best_q);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    inrun_d     = inrun_q;
    start_d     = start_q;
    found_d     = found_q;
    best_d      = best_q;
    place_d     = place_q;
    clr_d       = clr_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    occ_we = 1'b0; occ_wa = place_q; occ_wd = 1'b1;
    occ_ra = idx_q[SlotW-1:0];
    gt_we  = 1'b0; gt_wa = id_q; gt_wd = {1'b1, place_q};
    gt_ra  = id_q;
    case (state_q)
      StClear: begin
        gt_we  = 1'b1;
        gt_wa  = clr_q[IdW-1:0];
        gt_wd  = '0;
        occ_we = 1'b1;
        occ_wa = clr_q[SlotW-1:0];
        occ_wd = 1'b0;
        clr_d  = clr_q + 1'b1;
        if (clr_q[IdW-1:0] == '1) state_d = StIdle;
      end
      StIdle: begin
        gt_ra = req_i.guest_id;
        if (req_valid_i && req_ready_o) begin
          if (req_i.kind == KindLeave) begin
            state_d = StLeave;
          end else begin
            state_d = StScan;
            idx_d   = (SlotW+1)'(1);
            pos_d   = '0;
            inrun_d = 1'b0;
            found_d = 1'b0;
            best_d  = '0;
            place_d = '0;
          end
        end
        occ_ra = '0;
      end
      StScan: begin
        // occ_rd holds slot pos_q when pos_q < len
        if (run_end && run_better) begin
          found_d = 1'b1;
          best_d  = run_score;
          place_d = run_where;
        end
        if (pos_q == len) begin
          state_d = StWrite;
        end else begin
          if (!occ_rd && !inrun_q) begin
            start_d = pos_q[SlotW-1:0];
          end
          inrun_d = !occ_rd;
          pos_d   = pos_q + 1'b1;
          idx_d   = idx_q + 1'b1;
        end
      end
      StWrite: begin
        state_d     = StIdle;
        rsp_valid_d = 1'b1;
        if (found_q) begin
          occ_we = 1'b1;
          gt_we  = 1'b1;
          rsp_d  = '{slot: 7'(place_q) + 7'd1, row_full: 1'b0};
        end else begin
          rsp_d  = '{slot: 7'd0, row_full: 1'b1};
        end
      end
      StLeave: begin
        state_d = StFree;
      end
      StFree: begin
        state_d = StIdle;
        if (gt_rd[EntryW-1]) begin
          occ_we = 1'b1;
          occ_wa = gt_rd[SlotW-1:0];
          occ_wd = 1'b0;
          gt_we  = 1'b1;
          gt_wd  = '0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
      cfg_q       <= SlotsReset;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
      if (psel && penable && pwrite && paddr[AddrW+1:2] == RegSlotsInUse) begin
        cfg_q <= pwdata[CfgW-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    inrun_q <= inrun_d;
    start_q <= start_d;
    found_q <= found_d;
    best_q  <= best_d;
    place_q <= place_d;
    rsp_q   <= rsp_d;
    if (req_valid_i && req_ready_o) id_q <= req_i.guest_id;
  end

  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !req_ready_o) else $error("request taken while busy");
  a_rsp_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |=> rsp_valid_o) else $error("arrival lost response");
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.row_full) |-> (rsp_o.slot == 7'd0)) else $error("bad full");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.row_full) |-> (rsp_o.slot != 7'd0)) else $error("bad slot");

endmodule

[rtl/mgsa_ram.sv]
module mgsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
